@@ hdl/twra_pkg.sv @@
package twra_pkg;

  localparam int DEF_RING_DEPTH = 256;

  // field widths
  localparam int TIME_W = 32;
  localparam int DIST_W = 24;
  localparam int AMPL_W = 16;
  localparam int WIN_W  = 16;
  localparam int RATE_W = 14;
  localparam int CH_N   = 3;

  // divider dividend width, covers sums at the deepest ring
  localparam int DIV_W  = 40;
  localparam int DVS_W  = 32;

  localparam logic [DIST_W-1:0] VALID_DIST  = 24'd128;
  localparam logic [WIN_W-1:0]  MIN_KEEP_MS = 16'd750;
  localparam logic [TIME_W-1:0] MIN_RATE_MS = 32'd250;
  localparam logic [RATE_W-1:0] RATE_MAX    = 14'd16383;
  localparam logic [RATE_W-1:0] RATE_SCALE  = 14'd16000;

  // configuration register indexes
  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_BEEP   = 1'b1;

  // last averaging job (three distances then three amplitudes)
  localparam logic [2:0] JOB_LAST = 3'd5;

  typedef struct packed {
    logic [CH_N-1:0][AMPL_W-1:0] ampl;
    logic [CH_N-1:0][DIST_W-1:0] distance;
    logic [TIME_W-1:0]           stamp;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic rd_oldest;
    logic rd_walk;
    logic cap_new;
    logic ev_cmp;
    logic rate_init;
    logic rate_start;
    logic rate_cap;
    logic sum_step;
    logic job_start;
    logic job_cap;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic ev_more;
    logic rate_ok;
    logic avg_mode;
    logic walk_last;
    logic job_skip;
    logic job_last;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

@@ hdl/twra_divider.sv @@
module twra_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [twra_pkg::DIV_W-1:0]    dividend,
  input  logic [twra_pkg::DVS_W-1:0]    divisor,
  output logic                          done,
  output logic [twra_pkg::DIV_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(twra_pkg::DIV_W + 1);

  logic [twra_pkg::DIV_W-1:0] quo_r, quo_nxt;
  logic [twra_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [twra_pkg::DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       done_r, done_nxt;
  logic [twra_pkg::DVS_W:0]   trial;
  logic                       fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial    = {rem_r, quo_r[twra_pkg::DIV_W-1]};
    fits     = trial >= {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CNT_W'(twra_pkg::DIV_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = fits ? twra_pkg::DVS_W'(trial - {1'b0, dvs_r})
                      : trial[twra_pkg::DVS_W-1:0];
      quo_nxt  = {quo_r[twra_pkg::DIV_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = cnt_r == CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ hdl/twra_datapath.sv @@
module twra_datapath #(
  parameter int RING_DEPTH = twra_pkg::DEF_RING_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  twra_pkg::cmd_t                cmd,
  output twra_pkg::stat_t               stat,
  input  twra_pkg::entry_t              in_entry,
  input  logic                          cfg_we,
  input  logic                          cfg_sel,
  input  logic [twra_pkg::WIN_W-1:0]    cfg_value,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [twra_pkg::CH_N-1:0][twra_pkg::DIST_W-1:0] out_dist,
  output logic [twra_pkg::CH_N-1:0][twra_pkg::AMPL_W-1:0] out_ampl,
  output logic [twra_pkg::CH_N-1:0]     out_mask,
  output logic [twra_pkg::RATE_W-1:0]   out_rate,
  output logic                          out_rate_valid,
  output logic                          out_beep
);

  localparam int AW   = $clog2(RING_DEPTH);
  localparam int DS_W = twra_pkg::DIST_W + AW;
  localparam int AS_W = twra_pkg::AMPL_W + AW;
  localparam int RM_W = AW + twra_pkg::RATE_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

  function automatic logic [AW-1:0] slot_after(input logic [AW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  // sample ring
  twra_pkg::entry_t mem [RING_DEPTH];
  twra_pkg::entry_t rd_q;
  logic [AW-1:0]    rd_addr;

  // ring pointers and config
  logic [AW-1:0]  free_r, free_nxt, oldest_r, oldest_nxt, walk_r, walk_nxt;
  logic [AW-1:0]  newest, count;
  logic           full;
  logic [twra_pkg::WIN_W-1:0] window_r, window_nxt, limit;
  logic           beep_en_r, beep_en_nxt;

  // per item work registers
  twra_pkg::entry_t              new_r, new_nxt;
  logic [twra_pkg::TIME_W-1:0]   told_r, told_nxt, span, ev_span;
  logic                          acc_v_r, acc_v_nxt;
  logic [twra_pkg::CH_N-1:0][DS_W-1:0] dsum_r, dsum_nxt;
  logic [twra_pkg::CH_N-1:0][AS_W-1:0] asum_r, asum_nxt;
  logic [twra_pkg::CH_N-1:0][AW-1:0]   n_r, n_nxt;
  logic [2:0]                    job_r, job_nxt;
  logic [1:0]                    ch;
  logic                          job_amp;

  // result and output registers
  logic [twra_pkg::CH_N-1:0][twra_pkg::DIST_W-1:0] res_d_r, res_d_nxt;
  logic [twra_pkg::CH_N-1:0][twra_pkg::AMPL_W-1:0] res_a_r, res_a_nxt;
  logic [twra_pkg::CH_N-1:0]     res_m_r, res_m_nxt;
  logic [twra_pkg::RATE_W-1:0]   res_rate_r, res_rate_nxt;
  logic                          res_rv_r, res_rv_nxt, beep_r, beep_nxt;
  logic                          ov_r, ov_nxt;
  logic [twra_pkg::CH_N-1:0][twra_pkg::DIST_W-1:0] od_r;
  logic [twra_pkg::CH_N-1:0][twra_pkg::AMPL_W-1:0] oa_r;
  logic [twra_pkg::CH_N-1:0]     om_r;
  logic [twra_pkg::RATE_W-1:0]   orate_r;
  logic                          orv_r, obeep_r;

  // divider
  logic                          div_start;
  logic [twra_pkg::DIV_W-1:0]    div_dividend, div_q;
  logic [twra_pkg::DVS_W-1:0]    div_divisor;
  logic                          div_done;
  logic [RM_W-1:0]               rate_num;

  twra_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // ring pointer arithmetic
  assign full    = slot_after(free_r) == oldest_r;
  assign newest  = (free_r == '0) ? LAST_SLOT : free_r - 1'b1;
  assign count   = (free_r >= oldest_r) ? free_r - oldest_r
                                        : AW'(RING_DEPTH + free_r - oldest_r);
  assign limit   = (window_r > twra_pkg::MIN_KEEP_MS) ? window_r : twra_pkg::MIN_KEEP_MS;
  assign span    = new_r.stamp - told_r;
  assign ev_span = new_r.stamp - rd_q.stamp;
  assign rd_addr = cmd.rd_walk ? walk_r : (cmd.rd_oldest ? oldest_r : newest);

  // job channel select
  assign job_amp = job_r >= 3'd3;
  assign ch      = job_amp ? 2'(job_r - 3'd3) : job_r[1:0];

  // divider operand select
  assign rate_num     = RM_W'(count - 1'b1) * RM_W'(twra_pkg::RATE_SCALE);
  assign div_start    = cmd.rate_start | cmd.job_start;
  assign div_dividend = cmd.rate_start ? twra_pkg::DIV_W'(rate_num)
                      : (job_amp ? twra_pkg::DIV_W'(asum_r[ch])
                                 : twra_pkg::DIV_W'(dsum_r[ch]));
  assign div_divisor  = cmd.rate_start ? span : twra_pkg::DVS_W'(n_r[ch]);

  // status to controller
  always_comb begin
    stat.ev_more   = (oldest_r != newest) && (ev_span > {16'b0, limit})
                     && (slot_after(oldest_r) != newest);
    stat.rate_ok   = (count >= AW'(2)) && (span >= twra_pkg::MIN_RATE_MS);
    stat.avg_mode  = (count >= AW'(2)) && (window_r != '0);
    stat.walk_last = slot_after(walk_r) == free_r;
    stat.job_skip  = n_r[ch] == '0;
    stat.job_last  = job_r == twra_pkg::JOB_LAST;
    stat.div_done  = div_done;
    stat.out_free  = !ov_r || out_ready;
  end

  // ring memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.accept && !full) begin
      mem[free_r] <= in_entry;
    end
    rd_q <= mem[rd_addr];
  end

  // next state of working registers
  always_comb begin
    free_nxt     = free_r;
    oldest_nxt   = oldest_r;
    walk_nxt     = walk_r;
    window_nxt   = window_r;
    beep_en_nxt  = beep_en_r;
    new_nxt      = new_r;
    told_nxt     = told_r;
    acc_v_nxt    = cmd.sum_step;
    dsum_nxt     = dsum_r;
    asum_nxt     = asum_r;
    n_nxt        = n_r;
    job_nxt      = job_r;
    res_d_nxt    = res_d_r;
    res_a_nxt    = res_a_r;
    res_m_nxt    = res_m_r;
    res_rate_nxt = res_rate_r;
    res_rv_nxt   = res_rv_r;
    beep_nxt     = beep_r;
    ov_nxt       = ov_r;

    // configuration writes
    if (cfg_we) begin
      if (cfg_sel == twra_pkg::CFG_WINDOW) window_nxt = cfg_value;
      else beep_en_nxt = cfg_value[0];
    end

    // item accept, append unless full
    if (cmd.accept) begin
      beep_nxt = beep_en_r && ((in_entry.distance[0] > twra_pkg::VALID_DIST) ||
                               (in_entry.distance[1] > twra_pkg::VALID_DIST) ||
                               (in_entry.distance[2] > twra_pkg::VALID_DIST));
      if (!full) free_nxt = slot_after(free_r);
    end

    if (cmd.cap_new) new_nxt = rd_q;

    // eviction step
    if (cmd.ev_cmp) begin
      told_nxt = rd_q.stamp;
      if (stat.ev_more) oldest_nxt = slot_after(oldest_r);
    end

    // defaults for the result: newest sample, no rate
    if (cmd.rate_init) begin
      res_d_nxt    = new_r.distance;
      res_a_nxt    = new_r.ampl;
      res_m_nxt    = '0;
      res_rate_nxt = '0;
      res_rv_nxt   = 1'b0;
      walk_nxt     = oldest_r;
      dsum_nxt     = '0;
      asum_nxt     = '0;
      n_nxt        = '0;
      job_nxt      = '0;
    end

    if (cmd.rate_cap) begin
      res_rate_nxt = (div_q > twra_pkg::DIV_W'(twra_pkg::RATE_MAX)) ? twra_pkg::RATE_MAX
                     : div_q[twra_pkg::RATE_W-1:0];
      res_rv_nxt   = 1'b1;
    end

    // ring walk and accumulation
    if (cmd.sum_step) walk_nxt = slot_after(walk_r);
    if (acc_v_r) begin
      for (int k = 0; k < twra_pkg::CH_N; k++) begin
        if (rd_q.distance[k] > twra_pkg::VALID_DIST) begin
          dsum_nxt[k] = dsum_r[k] + DS_W'(rd_q.distance[k]);
          asum_nxt[k] = asum_r[k] + AS_W'(rd_q.ampl[k]);
          n_nxt[k]    = n_r[k] + 1'b1;
        end
      end
    end

    // store one average, or zero with mask when channel empty
    if (cmd.job_cap) begin
      if (job_amp) begin
        res_a_nxt[ch] = stat.job_skip ? '0 : div_q[twra_pkg::AMPL_W-1:0];
      end else begin
        res_d_nxt[ch] = stat.job_skip ? '0 : div_q[twra_pkg::DIST_W-1:0];
        res_m_nxt[ch] = stat.job_skip;
      end
      job_nxt = job_r + 1'b1;
    end

    // output register
    if (ov_r && out_ready) ov_nxt = 1'b0;
    if (cmd.out_load) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r    <= '0;
      oldest_r  <= '0;
      window_r  <= '0;
      beep_en_r <= 1'b0;
      acc_v_r   <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      free_r    <= free_nxt;
      oldest_r  <= oldest_nxt;
      window_r  <= window_nxt;
      beep_en_r <= beep_en_nxt;
      acc_v_r   <= acc_v_nxt;
      ov_r      <= ov_nxt;
    end
    walk_r     <= walk_nxt;
    new_r      <= new_nxt;
    told_r     <= told_nxt;
    dsum_r     <= dsum_nxt;
    asum_r     <= asum_nxt;
    n_r        <= n_nxt;
    job_r      <= job_nxt;
    res_d_r    <= res_d_nxt;
    res_a_r    <= res_a_nxt;
    res_m_r    <= res_m_nxt;
    res_rate_r <= res_rate_nxt;
    res_rv_r   <= res_rv_nxt;
    beep_r     <= beep_nxt;
    if (cmd.out_load) begin
      od_r    <= res_d_r;
      oa_r    <= res_a_r;
      om_r    <= res_m_r;
      orate_r <= res_rate_r;
      orv_r   <= res_rv_r;
      obeep_r <= beep_r;
    end
  end

  assign out_valid      = ov_r;
  assign out_dist       = od_r;
  assign out_ampl       = oa_r;
  assign out_mask       = om_r;
  assign out_rate       = orate_r;
  assign out_rate_valid = orv_r;
  assign out_beep       = obeep_r;

endmodule

@@ hdl/twra_ctrl.sv @@
module twra_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  twra_pkg::stat_t stat,
  output twra_pkg::cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_RDNEW  = 12'b000000000010,
    S_CAPNEW = 12'b000000000100,
    S_EVCMP  = 12'b000000001000,
    S_EVRD   = 12'b000000010000,
    S_RATE   = 12'b000000100000,
    S_RDIV   = 12'b000001000000,
    S_SUM    = 12'b000010000000,
    S_SUMEND = 12'b000100000000,
    S_JOB    = 12'b001000000000,
    S_JDIV   = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  // sequencing of one item
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_RDNEW;
        end
      end
      S_RDNEW: state_nxt = S_CAPNEW;
      S_CAPNEW: begin
        cmd.cap_new   = 1'b1;
        cmd.rd_oldest = 1'b1;
        state_nxt     = S_EVCMP;
      end
      S_EVCMP: begin
        cmd.ev_cmp = 1'b1;
        state_nxt  = stat.ev_more ? S_EVRD : S_RATE;
      end
      S_EVRD: begin
        cmd.rd_oldest = 1'b1;
        state_nxt     = S_EVCMP;
      end
      S_RATE: begin
        cmd.rate_init = 1'b1;
        if (stat.rate_ok) begin
          cmd.rate_start = 1'b1;
          state_nxt      = S_RDIV;
        end else begin
          state_nxt = stat.avg_mode ? S_SUM : S_DONE;
        end
      end
      S_RDIV: begin
        if (stat.div_done) begin
          cmd.rate_cap = 1'b1;
          state_nxt    = stat.avg_mode ? S_SUM : S_DONE;
        end
      end
      S_SUM: begin
        cmd.rd_walk  = 1'b1;
        cmd.sum_step = 1'b1;
        if (stat.walk_last) state_nxt = S_SUMEND;
      end
      S_SUMEND: state_nxt = S_JOB;
      S_JOB: begin
        if (stat.job_skip) begin
          cmd.job_cap = 1'b1;
          state_nxt   = stat.job_last ? S_DONE : S_JOB;
        end else begin
          cmd.job_start = 1'b1;
          state_nxt     = S_JDIV;
        end
      end
      S_JDIV: begin
        if (stat.div_done) begin
          cmd.job_cap = 1'b1;
          state_nxt   = stat.job_last ? S_DONE : S_JOB;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/time_window_range_averager_unit.sv @@
// Time-window moving average for a three-target rangefinder. Each accepted
// sample is appended to a ring of RING_DEPTH slots (one slot always stays
// free; a sample arriving at a full ring is dropped), old samples are evicted
// while the span exceeds max(window_ms, 750 ms) with at least two kept, and
// one result follows per sample: the sample rate when the span is 250 ms or
// more, and either the newest stored sample or per-channel averages of
// distances above 0.5 m and their amplitudes. Items are handled one at a
// time, in steps: a compare and a read per evicted sample, a division for
// the rate when it is computed, and a walk over the held samples plus up to
// six divisions for the averages when averaging; the 40-bit radix-2 divider
// is shared by the rate and the averages. A finished result waits in
// the output register while the next sample is taken. Configuration
// registers: index 0 window_ms, index 1 beep_enable.
module time_window_range_averager_unit #(
  parameter int RING_DEPTH = twra_pkg::DEF_RING_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // sample_time_ms, distance_a, distance_b, distance_c,
  // amplitude_a, amplitude_b, amplitude_c
  input  logic [151:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // shown_distance_a, shown_distance_b, shown_distance_c, shown_amplitude_a,
  // shown_amplitude_b, shown_amplitude_c, no_average_mask, rate_hz_x16,
  // rate_valid, beep_request, zero fill
  output logic [143:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);

  twra_pkg::cmd_t   cmd;
  twra_pkg::stat_t  stat;
  twra_pkg::entry_t in_entry;
  logic [twra_pkg::CH_N-1:0][twra_pkg::DIST_W-1:0] o_dist;
  logic [twra_pkg::CH_N-1:0][twra_pkg::AMPL_W-1:0] o_ampl;
  logic [twra_pkg::CH_N-1:0]   o_mask;
  logic [twra_pkg::RATE_W-1:0] o_rate;
  logic                        o_rv, o_beep;

  // unpack input transfer
  assign in_entry.stamp       = in_tdata[31:0];
  assign in_entry.distance[0] = in_tdata[55:32];
  assign in_entry.distance[1] = in_tdata[79:56];
  assign in_entry.distance[2] = in_tdata[103:80];
  assign in_entry.ampl[0]     = in_tdata[119:104];
  assign in_entry.ampl[1]     = in_tdata[135:120];
  assign in_entry.ampl[2]     = in_tdata[151:136];

  assign cfg_ready = 1'b1;

  twra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  twra_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_entry       (in_entry),
    .cfg_we         (cfg_valid),
    .cfg_sel        (cfg_index),
    .cfg_value      (cfg_data),
    .out_ready      (out_tready),
    .out_valid      (out_tvalid),
    .out_dist       (o_dist),
    .out_ampl       (o_ampl),
    .out_mask       (o_mask),
    .out_rate       (o_rate),
    .out_rate_valid (o_rv),
    .out_beep       (o_beep)
  );

  // pack result transfer
  assign out_tdata = {5'b0, o_beep, o_rv, o_rate, o_mask,
                      o_ampl[2], o_ampl[1], o_ampl[0],
                      o_dist[2], o_dist[1], o_dist[0]};

endmodule
